// ----- hw/rtl/speech_command_framer_defines.svh -----
// Assertion macros used by the checker file of the speech command framer.
`ifndef SPEECH_COMMAND_FRAMER_DEFINES_SVH
`define SPEECH_COMMAND_FRAMER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define SCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scf check failed: same-cycle implication");

// Next-cycle implication, checked only while out of reset.
`define SCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scf check failed: next-cycle implication");

`endif

// ----- hw/rtl/scf_pkg.sv -----
package scf_pkg;

    localparam logic [7:0]  HDR_START = 8'hFD;
    localparam logic [7:0]  HDR_CMD   = 8'h01;
    localparam logic [15:0] LEN_EXTRA = 16'd3;

    typedef logic [2:0] t_step;

    // Steps of start ops, then of payload ops; a checksum step closes the frame.
    localparam t_step STEP_SYNC = 3'd0;
    localparam t_step STEP_LENH = 3'd1;
    localparam t_step STEP_LENL = 3'd2;
    localparam t_step STEP_CMD  = 3'd3;
    localparam t_step STEP_ENC  = 3'd4;
    localparam t_step STEP_SUMH = 3'd5;
    localparam t_step STEP_DATA = 3'd0;
    localparam t_step STEP_SUMD = 3'd1;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op_kind;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        t_op_kind    kind;
        logic        last;   // a checksum closes the frame after this op
        logic [15:0] total;  // length field of the header, start ops only
        logic [7:0]  value;  // encoding byte or payload byte
    } t_op;

endpackage

// ----- hw/rtl/scf_front.sv -----
module scf_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_command,
    input  logic [15:0]  i_payload_length,
    input  logic [7:0]   i_text_encoding,
    input  logic [7:0]   i_data_byte,
    input  logic         i_queue_full,
    output logic         o_push,
    output scf_pkg::t_op o_op
);
    import scf_pkg::*;

    logic        r_open;
    logic [15:0] r_left;
    logic        n_open;
    logic [15:0] n_left;
    logic        accept;

    assign accept = i_in_valid && !i_queue_full;

    always_comb begin
        n_open       = r_open;
        n_left       = r_left;
        o_push       = 1'b0;
        o_op.kind    = OP_START;
        o_op.last    = 1'b0;
        o_op.total   = i_payload_length + LEN_EXTRA;
        o_op.value   = i_text_encoding;
        if (accept) begin
            if (i_command == 1'b0) begin
                o_push    = 1'b1;
                o_op.last = (i_payload_length == 16'd0);
                n_open    = (i_payload_length != 16'd0);
                n_left    = i_payload_length;
            end else if (r_open) begin
                // Payload bytes outside an open frame are dropped here.
                o_push     = 1'b1;
                o_op.kind  = OP_DATA;
                o_op.value = i_data_byte;
                o_op.last  = (r_left == 16'd1);
                n_left     = r_left - 16'd1;
                n_open     = (r_left != 16'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 16'd0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

// ----- hw/rtl/scf_queue.sv -----
module scf_queue #(
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  scf_pkg::t_op i_op,
    input  logic         i_pop,
    output scf_pkg::t_op o_head,
    output logic         o_empty,
    output logic         o_full
);
    import scf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/scf_back.sv -----
module scf_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  scf_pkg::t_op i_head,
    input  logic         i_empty,
    output logic         o_pop,
    input  logic         i_out_stall,
    output logic         o_out_valid,
    output logic [7:0]   o_out_byte,
    output logic         o_frame_end
);
    import scf_pkg::*;

    t_step      r_step;
    logic [7:0] r_xor;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_frame_end;

    logic       can_adv;
    logic       fire;
    logic [7:0] emit_byte;
    logic       is_sum;
    logic       last_step;
    logic [7:0] n_xor;

    assign can_adv = !r_out_valid || !i_out_stall;
    assign fire    = can_adv && !i_empty;
    assign o_pop   = fire && last_step;

    always_comb begin
        emit_byte = r_xor;
        is_sum    = 1'b0;
        last_step = 1'b0;
        case (i_head.kind)
            OP_START: begin
                case (r_step)
                    STEP_SYNC: emit_byte = HDR_START;
                    STEP_LENH: emit_byte = i_head.total[15:8];
                    STEP_LENL: emit_byte = i_head.total[7:0];
                    STEP_CMD:  emit_byte = HDR_CMD;
                    STEP_ENC:  emit_byte = i_head.value;
                    default:   is_sum    = 1'b1;
                endcase
                last_step = ((r_step == STEP_ENC) && !i_head.last) || (r_step == STEP_SUMH);
            end
            OP_DATA: begin
                if (r_step == STEP_DATA) begin
                    emit_byte = i_head.value;
                end else begin
                    is_sum = 1'b1;
                end
                last_step = ((r_step == STEP_DATA) && !i_head.last) || (r_step == STEP_SUMD);
            end
            default: begin
                last_step = 1'b1;
            end
        endcase
        // The sync byte restarts the checksum, so an abandoned frame leaves no trace.
        if (is_sum) begin
            n_xor = 8'd0;
        end else if ((i_head.kind == OP_START) && (r_step == STEP_SYNC)) begin
            n_xor = emit_byte;
        end else begin
            n_xor = r_xor ^ emit_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_SYNC;
            r_xor       <= 8'd0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_step      <= last_step ? STEP_SYNC : r_step + 3'd1;
            r_xor       <= n_xor;
            r_out_valid <= 1'b1;
        end else if (can_adv) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte  <= emit_byte;
            r_frame_end <= is_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_frame_end;

endmodule

// ----- hw/rtl/speech_command_framer.sv -----
// Channel   Direction  Handshake               Payload
// in        request    i_in_valid / o_in_stall  i_command, i_payload_length,
//                                               i_text_encoding, i_data_byte
// out       byte       o_out_valid / i_out_stall o_out_byte, o_frame_end
//
// Each payload request gives one output byte, two when it closes the frame; a
// start gives the five header bytes, plus the checksum when the length is zero.
// The back end sends one byte per cycle while i_out_stall is low, so payload
// requests run one per cycle, but for the one that closes the frame.
// Reset is synchronous and active low and empties the request queue. o_in_stall
// rises only when the queue is full; i_out_stall holds the output register.
module speech_command_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_text_encoding,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);
    import scf_pkg::*;

    // The front end tracks whether a frame is open and how many payload bytes it
    // still expects. It classifies every request into a queued operation and
    // drops payload bytes that arrive with no frame open.
    t_op  front_op;
    logic front_push;
    t_op  queue_head;
    logic queue_empty;
    logic queue_full;
    logic back_pop;

    assign o_in_stall = queue_full;

    scf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_command        (i_command),
        .i_payload_length (i_payload_length),
        .i_text_encoding  (i_text_encoding),
        .i_data_byte      (i_data_byte),
        .i_queue_full     (queue_full),
        .o_push           (front_push),
        .o_op             (front_op)
    );

    // The queue lets requests keep flowing while the back end works through a
    // header burst or waits on the link. QUEUE_DEPTH must be at least two.
    scf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_op    (front_op),
        .i_pop   (back_pop),
        .o_head  (queue_head),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    // The back end walks each operation one byte per cycle while the output is not
    // stalled, keeps the running XOR checksum and owns the output register.
    scf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (queue_head),
        .i_empty     (queue_empty),
        .o_pop       (back_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

// ----- hw/rtl/scf_checker.sv -----
`include "speech_command_framer_defines.svh"

module scf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_frame_end
);

    // A stalled output byte stays in place.
    `SCF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_frame_end))

    // Leaving reset, the queue is empty and no byte is offered.
    `SCF_ASSERT_IMP(a_reset_clean, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid && !o_in_stall)

    // A full queue means the back end already has a byte on the output.
    `SCF_ASSERT_IMP(a_full_busy, i_clk, i_rst_n, o_in_stall, o_out_valid)

endmodule

bind speech_command_framer scf_checker u_scf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_frame_end (o_frame_end)
);
